// ----- hw/rtl/sparse_matrix_store_unit_defines.svh -----
// ---------------------------------------------------------------------------
// sparse matrix store assertion macros
// shared property forms used by the store's checks
// ---------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_STORE_UNIT_DEFINES_SVH
`define SPARSE_MATRIX_STORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sms_pkg.sv -----
// ---------------------------------------------------------------------------
// sms_pkg
// types and fixed constants of the sparse matrix store
// ---------------------------------------------------------------------------
package sms_pkg;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 32;
    localparam int RES_W   = 33;
    localparam int CFG_W   = 11;
    localparam int CFGIX_W = 2;
    localparam int AREA_W  = 2 * CFG_W;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFGIX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFGIX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    localparam logic signed [VAL_W-1:0] INT32_TOP = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [ROW_W-1:0]        row_index;
        logic [COL_W-1:0]        column_index;
        logic signed [VAL_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
    } t_entry;

endpackage

// ----- hw/rtl/sms_ram.sv -----
// ---------------------------------------------------------------------------
// sms_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module sms_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 256
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sparse_matrix_store_unit.sv -----
// ---------------------------------------------------------------------------
// sparse_matrix_store_unit
// sparse matrix held as a bounded table of (row, column, value) entries
// ---------------------------------------------------------------------------
// One item at a time. Entries live in a single ram and are scanned in order
// through its one read port, one entry per cycle. A read or write scans the
// stored entries up to the matching one (all of them when the cell has none);
// a max-minus-min query scans all stored entries; an index out of range or an
// unused command skips the scan and goes straight to the result. The result
// sits in an output register, so the next item is taken as soon as the
// previous one has been loaded there.
// Stored entries hold whatever was last written; no clearing pass is needed.
`include "sparse_matrix_store_unit_defines.svh"

module sparse_matrix_store_unit
    import sms_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int MAX_DIM  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFGIX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > AREA_W) ? CNT_W : AREA_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]              r_state, n_state;
    t_in_item                r_item, n_item;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_addr, n_addr;
    logic                    r_pend, n_pend;
    logic [ADDR_W-1:0]       r_pend_addr, n_pend_addr;
    logic                    r_found, n_found;
    logic [ADDR_W-1:0]       r_slot, n_slot;
    logic signed [VAL_W-1:0] r_old, n_old;
    logic signed [VAL_W-1:0] r_hi, n_hi;
    logic signed [VAL_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0]        r_inside, n_inside;
    logic [AREA_W-1:0]       r_area, n_area;
    logic [1:0]              r_status, n_status;
    logic [CFG_W-1:0]        r_row_count, r_column_count;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_item, n_out_item;

    logic [CFG_W-1:0]        rows_eff, cols_eff;
    logic                    ram_re, ram_we;
    logic [ADDR_W-1:0]       ram_raddr, ram_waddr;
    t_entry                  ram_wdata, ram_rdata;
    logic                    hit, in_area;
    logic signed [VAL_W-1:0] lo_adj;

    assign rows_eff = (32'(r_row_count) > MAX_DIM) ? CFG_W'(MAX_DIM) : r_row_count;
    assign cols_eff = (32'(r_column_count) > MAX_DIM) ? CFG_W'(MAX_DIM) : r_column_count;

    sms_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_area = ({1'b0, ram_rdata.row} < rows_eff) && ({1'b0, ram_rdata.column} < cols_eff);
    assign lo_adj  = ((CMP_W'(r_inside) < CMP_W'(r_area)) && (r_lo > 0)) ? '0 : r_lo;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_found     = r_found;
        n_slot      = r_slot;
        n_old       = r_old;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_inside    = r_inside;
        n_area      = r_area;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        hit         = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr[ADDR_W-1:0];
        ram_we      = 1'b0;
        ram_waddr   = r_slot;
        ram_wdata.row    = r_item.row_index;
        ram_wdata.column = r_item.column_index;
        ram_wdata.value  = r_item.write_value;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_addr   = '0;
                    n_pend   = 1'b0;
                    n_found  = 1'b0;
                    n_hi     = '0;
                    n_lo     = INT32_TOP;
                    n_inside = '0;
                    n_status = STATUS_OK;
                    n_area   = AREA_W'(rows_eff) * AREA_W'(cols_eff);
                    if (i_in_item.cmd == CMD_READ || i_in_item.cmd == CMD_WRITE) begin
                        if ({1'b0, i_in_item.row_index} >= rows_eff ||
                            {1'b0, i_in_item.column_index} >= cols_eff) begin
                            n_status = STATUS_RANGE;
                            n_state  = ST_FINISH;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end else if (i_in_item.cmd == CMD_QUERY) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // check the entry read last cycle
                if (r_pend) begin
                    if (r_item.cmd == CMD_QUERY) begin
                        if (in_area) begin
                            n_inside = r_inside + 1'b1;
                            if (ram_rdata.value > r_hi) begin
                                n_hi = ram_rdata.value;
                            end
                            if (ram_rdata.value < r_lo) begin
                                n_lo = ram_rdata.value;
                            end
                        end
                    end else if (ram_rdata.row == r_item.row_index &&
                                 ram_rdata.column == r_item.column_index) begin
                        hit     = 1'b1;
                        n_found = 1'b1;
                        n_slot  = r_pend_addr;
                        n_old   = ram_rdata.value;
                    end
                end
                if (hit) begin
                    n_pend  = 1'b0;
                    n_state = ST_FINISH;
                end else if (r_addr < r_count) begin
                    ram_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_addr[ADDR_W-1:0];
                    n_addr      = r_addr + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    n_out_item.status       = r_status;
                    n_out_item.result_value = '0;
                    if (r_status == STATUS_OK) begin
                        if (r_item.cmd == CMD_QUERY) begin
                            if (r_area != '0) begin
                                n_out_item.result_value = {r_hi[VAL_W-1], r_hi}
                                                        - {lo_adj[VAL_W-1], lo_adj};
                            end
                        end else if (r_item.cmd == CMD_READ || r_item.cmd == CMD_WRITE) begin
                            if (r_found) begin
                                n_out_item.result_value = {r_old[VAL_W-1], r_old};
                                if (r_item.cmd == CMD_WRITE) begin
                                    ram_we = 1'b1;
                                end
                            end else if (r_item.cmd == CMD_WRITE) begin
                                if (r_count == CNT_W'(CAPACITY)) begin
                                    n_out_item.status = STATUS_FULL;
                                end else begin
                                    // append at the end of the table
                                    ram_we    = 1'b1;
                                    ram_waddr = r_count[ADDR_W-1:0];
                                    n_count   = r_count + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_row_count    <= DIM_RESET;
            r_column_count <= DIM_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ROW_COUNT) begin
                    r_row_count <= i_cfg_data;
                end else if (i_cfg_index == CFG_COLUMN_COUNT) begin
                    r_column_count <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_addr      <= n_addr;
        r_pend_addr <= n_pend_addr;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_old       <= n_old;
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_inside    <= n_inside;
        r_area      <= n_area;
        r_status    <= n_status;
        r_out_item  <= n_out_item;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    `SMS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `SMS_ASSERT_NOW(a_write_at_finish, ram_we, r_state == ST_FINISH && n_out_valid, "table write outside result load")
    `SMS_ASSERT_NEXT(a_insert_counts, ram_we && !r_found, r_count == $past(r_count) + 1'b1, "insert did not grow count")

endmodule
